### hw/rtl/tcc_pkg.sv
package tcc_pkg;

    localparam int COORD_BITS = 10;
    localparam int POS_BITS = 10;
    localparam int CODE_BITS = 8;
    localparam int GLYPH_BITS = 7;
    localparam int SCREEN_BITS = 10;
    localparam int SUM_BITS = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 2;

    localparam int MAX_RES = 4;
    localparam int RES_IDX_BITS = $clog2(MAX_RES);
    localparam int RES_CNT_BITS = RES_IDX_BITS + 1;

    // power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = QPTR_BITS + 1;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_W = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_H = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_W = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_H = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURSOR = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE = 3'd5;

    localparam logic [CODE_BITS-1:0] SPACE_CODE = 8'd32;
    localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CODE_BITS-1:0] CR_CODE = 8'd13;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [1:0] {
        CMD_CHAR   = 2'd0,
        CMD_BLINK  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_CURSOR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_GLYPH  = 2'd0,
        OP_SCROLL = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        logic [GLYPH_BITS-1:0]  glyph_w;
        logic [GLYPH_BITS-1:0]  glyph_h;
        logic [SCREEN_BITS-1:0] screen_w;
        logic [SCREEN_BITS-1:0] screen_h;
        logic [CODE_BITS-1:0]   cursor_glyph;
        logic                   active;
    } t_cfg;

    typedef struct packed {
        t_op                  op;
        logic [CODE_BITS-1:0] code;
        logic [POS_BITS-1:0]  x;
        logic [POS_BITS-1:0]  y;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0]   res;
        logic [RES_CNT_BITS-1:0] cnt;
    } t_job;

    function automatic logic [POS_BITS-1:0] to_pos(input t_coord c);
        logic [COORD_BITS+POS_BITS-1:0] w;
        w = {{POS_BITS{1'b0}}, c};
        return w[POS_BITS-1:0];
    endfunction

endpackage

### hw/rtl/text_console_cursor_engine.sv
// the first result of an item is written into the queue when the item is accepted and is then
// loaded into the output register, when the queue and the output register are idle
// throughput: one input item per cycle while the queue has room; one result per cycle out
// while m_axis_tready is high; an item has k results, k from 0 to 4, sent out in turn
// the job queue holds 4 items with results between front and back
// reset (i_rst_n low at a clock edge): queue and output emptied, cursor at 0,0,
// cursor enabled and hidden, registers back to their defaults
module text_console_cursor_engine
    import tcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [15:0]              s_axis_tdata,  // char_code, cursor_on
    input  logic [2:0]               s_axis_tuser,  // command, message_first
    input  logic                     s_axis_tlast,  // message_last
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,  // glyph_code, pos_x, pos_y
    output logic [1:0]               m_axis_tuser,  // draw_op
    output logic                     m_axis_tlast,  // run_last
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_job    push_job;
    t_job    head_job;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    logic    accept;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_w <= 7'd8;
            r_cfg.glyph_h <= 7'd16;
            r_cfg.screen_w <= 10'd100;
            r_cfg.screen_h <= 10'd16;
            r_cfg.cursor_glyph <= 8'd95;
            r_cfg.active <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GLYPH_W:  r_cfg.glyph_w <= i_cfg_data[GLYPH_BITS-1:0];
                CFG_GLYPH_H:  r_cfg.glyph_h <= i_cfg_data[GLYPH_BITS-1:0];
                CFG_SCREEN_W: r_cfg.screen_w <= i_cfg_data[SCREEN_BITS-1:0];
                CFG_SCREEN_H: r_cfg.screen_h <= i_cfg_data[SCREEN_BITS-1:0];
                CFG_CURSOR:   r_cfg.cursor_glyph <= i_cfg_data[CODE_BITS-1:0];
                CFG_ACTIVE:   r_cfg.active <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign accept = s_axis_tvalid && s_axis_tready;

    tcc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (t_cmd'(s_axis_tuser[1:0])),
        .i_char   (s_axis_tdata[7:0]),
        .i_first  (s_axis_tuser[2]),
        .i_last   (s_axis_tlast),
        .i_on     (s_axis_tdata[8]),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_job    (push_job)
    );

    tcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    tcc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head_job),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, res.y, res.x, res.code};
    assign m_axis_tuser = res.op;

endmodule

### hw/rtl/tcc_front.sv
module tcc_front
    import tcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_cmd                 i_cmd,
    input  logic [CODE_BITS-1:0] i_char,
    input  logic                 i_first,
    input  logic                 i_last,
    input  logic                 i_on,
    input  t_cfg                 i_cfg,
    output logic                 o_push,
    output t_job                 o_job
);

    t_coord r_col, n_col;
    t_coord r_row, n_row;
    logic   r_en, n_en;
    logic   r_vis, n_vis;

    t_result             e [MAX_RES];
    logic [MAX_RES-1:0]  v;
    logic [SUM_BITS-1:0] sum_x;
    logic [SUM_BITS-1:0] sum_y2;
    logic [SUM_BITS-1:0] sum_y1;
    logic                wrap;
    logic                scroll_need;
    t_coord              line_row;
    logic                is_nl;
    logic                is_cr;
    logic [RES_CNT_BITS-1:0] cnt;

    assign sum_x = SUM_BITS'(r_col) + SUM_BITS'(i_cfg.glyph_w);
    assign sum_y1 = SUM_BITS'(r_row) + SUM_BITS'(i_cfg.glyph_h);
    assign sum_y2 = SUM_BITS'(r_row) + SUM_BITS'({i_cfg.glyph_h, 1'b0});
    assign wrap = sum_x > SUM_BITS'(i_cfg.screen_w);
    assign scroll_need = sum_y2 > SUM_BITS'(i_cfg.screen_h);
    assign line_row = scroll_need ? r_row : COORD_BITS'(sum_y1);
    assign is_nl = (i_char == NEWLINE_CODE);
    assign is_cr = (i_char == CR_CODE);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_en = r_en;
        n_vis = r_vis;
        v = '0;
        // slot order: cursor erase, scroll, glyph, cursor draw
        e[0] = '{op: OP_GLYPH, code: SPACE_CODE, x: to_pos(r_col), y: to_pos(r_row)};
        e[1] = '{op: OP_SCROLL, code: '0, x: '0, y: '0};
        e[2] = '{op: OP_GLYPH, code: i_char, x: to_pos(r_col), y: to_pos(r_row)};
        e[3] = '{op: OP_GLYPH, code: i_cfg.cursor_glyph, x: to_pos(r_col), y: to_pos(r_row)};
        unique case (i_cmd)
            CMD_CHAR: begin
                if (i_cfg.active) begin
                    v[0] = i_first && r_en && r_vis;
                    if (is_nl) begin
                        v[1] = scroll_need;
                        n_row = line_row;
                        n_col = '0;
                    end else if (is_cr) begin
                        n_col = '0;
                    end else if (wrap) begin
                        v[1] = scroll_need;
                        v[2] = 1'b1;
                        n_row = line_row;
                        e[2].x = '0;
                        e[2].y = to_pos(line_row);
                        n_col = COORD_BITS'(i_cfg.glyph_w);
                    end else begin
                        v[2] = 1'b1;
                        n_col = COORD_BITS'(sum_x);
                    end
                end
                if (i_last) begin
                    n_vis = 1'b0;
                    if (r_en && i_cfg.active) begin
                        n_vis = 1'b1;
                        v[3] = 1'b1;
                        e[3].x = to_pos(n_col);
                        e[3].y = to_pos(n_row);
                    end
                end
            end
            CMD_BLINK: begin
                if (r_en && i_cfg.active) begin
                    n_vis = !r_vis;
                    v[3] = 1'b1;
                    e[3].code = r_vis ? SPACE_CODE : i_cfg.cursor_glyph;
                end
            end
            CMD_CLEAR: begin
                v[0] = 1'b1;
                e[0] = '{op: OP_CLEAR, code: '0, x: '0, y: '0};
                n_col = '0;
                n_row = '0;
            end
            CMD_CURSOR: begin
                if (i_on && !r_en) begin
                    n_vis = 1'b1;
                    v[3] = i_cfg.active;
                end else if (!i_on && r_en) begin
                    v[3] = i_cfg.active;
                    e[3].code = SPACE_CODE;
                end
                n_en = i_on;
            end
        endcase
    end

    // pack valid slots in order
    always_comb begin
        o_job = '0;
        cnt = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            if (v[i]) begin
                o_job.res[cnt[RES_IDX_BITS-1:0]] = e[i];
                cnt = cnt + 1'b1;
            end
        end
        o_job.cnt = cnt;
    end

    assign o_push = i_accept && (cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_en <= 1'b1;
            r_vis <= 1'b0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_en <= n_en;
            r_vis <= n_vis;
        end
    end

endmodule

### hw/rtl/tcc_queue.sv
module tcc_queue
    import tcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/tcc_back.sv
module tcc_back
    import tcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_job    i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result,
    output logic    o_last
);

    logic [RES_IDX_BITS-1:0] r_idx;
    logic                    r_valid;
    t_result                 r_res;
    logic                    r_last;
    logic                    load;
    logic                    is_last;

    assign load = !i_empty && (!r_valid || i_ready);
    assign is_last = ((RES_CNT_BITS'(r_idx) + RES_CNT_BITS'(1)) == i_head.cnt);
    assign o_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx <= is_last ? '0 : r_idx + 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_head.res[r_idx];
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_result = r_res;
    assign o_last = r_last;

endmodule

### hw/rtl/tcc_checker.sv
module tcc_checker
    import tcc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled item changed");

    // a clear is the only result of its item
    a_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == OP_CLEAR |-> m_axis_tlast)
        else $error("clear not last of its run");

    a_nonglyph_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != OP_GLYPH |-> m_axis_tdata == '0)
        else $error("scroll or clear carries payload");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (.*);
